### rtl/core/swm_pkg.sv
// Shared constants for the sliding window minimum block.
// Holds the configuration register width and the input queue geometry.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

    // Width of the window length configuration register.
    localparam int CFG_W = 11;

    // Input queue between the front end and the engine.
    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

endpackage

### rtl/core/swm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both stacks of the window engine. No dependencies.
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/swm_front.sv
// Front end of the sliding window minimum: accepts input words and holds
// them in a short queue so the engine can stall on its own. Uses swm_pkg.
`timescale 1ns / 1ps

module swm_front #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    // Queue head toward the engine.
    output logic                          q_valid,
    input  logic                          q_pop,
    output logic signed [SAMPLE_BITS-1:0] q_sample,
    output logic                          q_restart
);

    logic signed [SAMPLE_BITS-1:0] smp_mem [swm_pkg::QUEUE_DEPTH];
    logic                          rst_mem [swm_pkg::QUEUE_DEPTH];

    logic [swm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [swm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [swm_pkg::QPTR_W:0]   count_reg, count_next;
    logic                       push;
    logic                       pop;

    assign in_ready  = (count_reg != (swm_pkg::QPTR_W + 1)'(swm_pkg::QUEUE_DEPTH));
    assign q_valid   = (count_reg != '0);
    assign q_sample  = smp_mem[rd_ptr_reg];
    assign q_restart = rst_mem[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = q_pop && q_valid;

    // Pointer and occupancy update; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + swm_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + swm_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (swm_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (swm_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            smp_mem[wr_ptr_reg] <= sample;
            rst_mem[wr_ptr_reg] <= restart;
        end
    end

endmodule

### rtl/core/swm_back.sv
// Window engine of the sliding window minimum: the two-stack queue with its
// counters, the stack transfer sequencer and the output register.
// Uses swm_ram for both stacks.
`timescale 1ns / 1ps

module swm_back #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]   k_eff,
    // Queue head from the front end.
    input  logic                                q_valid,
    output logic                                q_pop,
    input  logic signed [SAMPLE_BITS-1:0]       q_sample,
    input  logic                                q_restart,
    // Output channel.
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       window_min
);

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOVE = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              in_cnt_reg, in_cnt_next;
    logic [CNT_W-1:0]              out_cnt_reg, out_cnt_next;
    logic signed [SAMPLE_BITS-1:0] in_min_reg, in_min_next;
    logic signed [SAMPLE_BITS-1:0] top_reg, top_next;
    logic [CNT_W-1:0]              mv_left_reg, mv_left_next;
    logic [AW-1:0]                 mv_addr_reg, mv_addr_next;
    logic                          dv_reg, dv_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] window_min_reg, window_min_next;

    // Stack memory ports.
    logic                   in_we, in_re;
    logic [AW-1:0]          in_waddr, in_raddr;
    logic [SAMPLE_BITS-1:0] in_wdata, in_rdata;
    logic                   os_we, os_re;
    logic [AW-1:0]          os_waddr, os_raddr;
    logic [SAMPLE_BITS-1:0] os_wdata, os_rdata;

    // Working values.
    logic                          slot_free;
    logic [CNT_W-1:0]              in_c, out_c, total, below_idx;
    logic signed [SAMPLE_BITS-1:0] new_min, mv_val;

    assign slot_free  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign window_min = window_min_reg;

    always_comb
    begin
        state_next      = state_reg;
        in_cnt_next     = in_cnt_reg;
        out_cnt_next    = out_cnt_reg;
        in_min_next     = in_min_reg;
        top_next        = top_reg;
        mv_left_next    = mv_left_reg;
        mv_addr_next    = mv_addr_reg;
        dv_next         = dv_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        window_min_next = window_min_reg;
        q_pop           = 1'b0;
        in_we           = 1'b0;
        in_waddr        = '0;
        in_wdata        = q_sample;
        in_re           = 1'b0;
        in_raddr        = mv_addr_reg;
        os_we           = 1'b0;
        os_waddr        = out_cnt_reg[AW-1:0];
        os_re           = 1'b0;
        os_raddr        = '0;

        // A restart empties both stacks before the sample goes in.
        in_c      = q_restart ? '0 : in_cnt_reg;
        out_c     = q_restart ? '0 : out_cnt_reg;
        total     = in_c + out_c + CNT_W'(1);
        below_idx = out_c - CNT_W'(2);
        new_min   = (in_c == '0 || q_sample < in_min_reg) ? q_sample : in_min_reg;

        // Suffix minimum for the entry written during a transfer.
        mv_val = (out_cnt_reg == '0 || $signed(in_rdata) < top_reg)
            ? $signed(in_rdata) : top_reg;
        os_wdata = mv_val;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    // Push the new word onto the in-stack.
                    q_pop        = 1'b1;
                    in_we        = 1'b1;
                    in_waddr     = in_c[AW-1:0];
                    in_min_next  = new_min;
                    in_cnt_next  = in_c + CNT_W'(1);
                    out_cnt_next = out_c;
                    if (total >= k_eff)
                    begin
                        // Window full: report the minimum, then drop the oldest.
                        out_valid_next  = 1'b1;
                        window_min_next = (out_c != '0 && top_reg < new_min)
                            ? top_reg : new_min;
                        if (out_c != '0)
                        begin
                            out_cnt_next = out_c - CNT_W'(1);
                            if (out_c > CNT_W'(1))
                            begin
                                os_re      = 1'b1;
                                os_raddr   = below_idx[AW-1:0];
                                state_next = ST_LOAD;
                            end
                        end
                        else
                        begin
                            // Out-stack empty: move the in-stack across.
                            mv_left_next = in_c + CNT_W'(1);
                            mv_addr_next = in_c[AW-1:0];
                            in_cnt_next  = '0;
                            dv_next      = 1'b0;
                            state_next   = ST_MOVE;
                        end
                    end
                end
            end

            ST_MOVE:
            begin
                // Read the in-stack from its top down, one entry a cycle.
                dv_next = (mv_left_reg != '0);
                if (mv_left_reg != '0)
                begin
                    in_re        = 1'b1;
                    mv_addr_next = mv_addr_reg - AW'(1);
                    mv_left_next = mv_left_reg - CNT_W'(1);
                end
                if (dv_reg)
                begin
                    if (mv_left_reg == '0)
                    begin
                        // The oldest word is the one being dropped: not stored.
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        os_we        = 1'b1;
                        top_next     = mv_val;
                        out_cnt_next = out_cnt_reg + CNT_W'(1);
                    end
                end
            end

            ST_LOAD:
            begin
                // New top of the out-stack arrives from memory.
                top_next   = $signed(os_rdata);
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            in_min_reg    <= '0;
            mv_left_reg   <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            in_min_reg    <= in_min_next;
            mv_left_reg   <= mv_left_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        mv_addr_reg    <= mv_addr_next;
        window_min_reg <= window_min_next;
    end

    // In-stack: raw samples in arrival order.
    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_in_stack (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    // Out-stack: suffix minimums.
    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_out_stack (
        .clk   (clk),
        .we    (os_we),
        .waddr (os_waddr),
        .wdata (os_wdata),
        .re    (os_re),
        .raddr (os_raddr),
        .rdata (os_rdata)
    );

endmodule

### rtl/core/sliding_window_minimum.sv
// Top level of the sliding window minimum block.
// Holds the window length register and joins swm_front and swm_back.
// Uses swm_pkg.
`timescale 1ns / 1ps

// Sliding window minimum over a stream of signed samples.
// Input channel: sample and restart with in_valid / in_ready. A word with
// restart high empties the window before its sample is taken in.
// Output channel: window_min with out_valid / out_ready. Once the window
// holds window_length samples, every word gives the minimum of the window
// and the oldest sample is dropped; before that, words give no result.
// window_length is to be written through window_length_we only while the
// block is idle; the block itself does not enforce this. Zero counts as 1
// and values above MAX_WINDOW count as MAX_WINDOW. A word passes through
// the input queue and then the swm_back engine before its result is held
// in the output register. A word without a result only goes onto the
// in-stack. A word with a result also reads the new out-stack top from
// memory while the out-stack holds more than one entry, but not when it
// holds exactly one. When the out-stack is empty, the in-stack is moved
// across through the stack memory read port, one entry a cycle; the engine
// takes no new word meanwhile, and a four-word input queue keeps accepting.
// Reset empties both stacks and sets window_length to 1; no clearing pass.
// A stalled receiver holds the result in the output register; the engine
// waits only when it has the next word and the register is still full.
module sliding_window_minimum #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration.
    input  logic                          window_length_we,
    input  logic [swm_pkg::CFG_W-1:0]     window_length,
    // Input channel.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          restart,
    // Output channel.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] window_min
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int KW    = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;

    logic [swm_pkg::CFG_W-1:0]     window_length_reg;
    logic [KW-1:0]                 wl_ext;
    logic [KW-1:0]                 k_wide;
    logic [CNT_W-1:0]              k_eff;
    logic                          q_valid;
    logic                          q_pop;
    logic signed [SAMPLE_BITS-1:0] q_sample;
    logic                          q_restart;

    // Window length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= swm_pkg::CFG_W'(1);
        end
        else if (window_length_we)
        begin
            window_length_reg <= window_length;
        end
    end

    // Clamp the window length to the range the stacks can hold.
    always_comb
    begin
        wl_ext = KW'(window_length_reg);
        if (wl_ext == '0)
        begin
            k_wide = KW'(1);
        end
        else if (wl_ext > KW'(MAX_WINDOW))
        begin
            k_wide = KW'(MAX_WINDOW);
        end
        else
        begin
            k_wide = wl_ext;
        end
        k_eff = k_wide[CNT_W-1:0];
    end

    swm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .restart   (restart),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_sample  (q_sample),
        .q_restart (q_restart)
    );

    swm_back #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .k_eff      (k_eff),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_sample   (q_sample),
        .q_restart  (q_restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .window_min (window_min)
    );

endmodule
